// ----- hdl/mips_exu_pkg.sv -----
// Package for the integer execute unit: opcodes, function codes, syscall codes, sequencer
// states and the multiply/divide request and response records. No dependencies.
package mips_exu_pkg;

	localparam logic [5:0] OP_RTYPE = 6'h00;
	localparam logic [5:0] OP_BEQ   = 6'h04;
	localparam logic [5:0] OP_BNE   = 6'h05;
	localparam logic [5:0] OP_ADDI  = 6'h08;
	localparam logic [5:0] OP_SLTI  = 6'h0A;
	localparam logic [5:0] OP_SLTIU = 6'h0B;
	localparam logic [5:0] OP_ANDI  = 6'h0C;
	localparam logic [5:0] OP_ORI   = 6'h0D;
	localparam logic [5:0] OP_XORI  = 6'h0E;
	localparam logic [5:0] OP_LUI   = 6'h0F;

	localparam logic [5:0] FN_SLL  = 6'h00;
	localparam logic [5:0] FN_SRL  = 6'h02;
	localparam logic [5:0] FN_SRA  = 6'h03;
	localparam logic [5:0] FN_JR   = 6'h08;
	localparam logic [5:0] FN_SYS  = 6'h0C;
	localparam logic [5:0] FN_MFHI = 6'h10;
	localparam logic [5:0] FN_MFLO = 6'h12;
	localparam logic [5:0] FN_MULT = 6'h18;
	localparam logic [5:0] FN_DIV  = 6'h1A;
	localparam logic [5:0] FN_ADD  = 6'h20;
	localparam logic [5:0] FN_SUB  = 6'h22;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_XOR  = 6'h26;
	localparam logic [5:0] FN_NOR  = 6'h27;
	localparam logic [5:0] FN_SLT  = 6'h2A;

	localparam logic [31:0] SYS_PRINT_INT = 32'd1;
	localparam logic [31:0] SYS_EXIT      = 32'd10;
	localparam logic [4:0]  REG_V0 = 5'd2;
	localparam logic [4:0]  REG_A0 = 5'd4;
	localparam logic [15:0] TEXT_LIMIT_RST = 16'h2000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ_A,
		ST_READ_B,
		ST_EXEC,
		ST_ITER,
		ST_DONE
	} state_t;

	// Shared unit control: start pulse, selection of the iterative operation and the two operands
	typedef struct packed {
		logic start;
		logic is_div;
		logic [31:0] a;
		logic [31:0] b;
	} iter_req_t;

	typedef struct packed {
		logic [31:0] hi;
		logic [31:0] lo;
	} iter_rsp_t;

endpackage

// ----- hdl/mips_exu_muldiv.sv -----
// Shared iterative multiply/divide unit: one shift-add or shift-subtract step per cycle.
// Depends on mips_exu_pkg.
module mips_exu_muldiv (
	input  logic clk,
	input  logic arst_n,
	input  mips_exu_pkg::iter_req_t req,
	output mips_exu_pkg::iter_rsp_t rsp
);

	logic        busy_q;
	logic        div_q;
	logic        neg_q_q;
	logic        neg_r_q;
	logic [5:0]  cnt_q;
	logic [31:0] acc_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [32:0] sum;
	logic [32:0] trial;
	logic [31:0] abs_a;
	logic [31:0] abs_b;
	logic [63:0] prod_abs;
	logic [63:0] prod;
	logic [31:0] qf;
	logic [31:0] rf;

	assign abs_a = req.a[31] ? (~req.a + 32'd1) : req.a;
	assign abs_b = req.b[31] ? (~req.b + 32'd1) : req.b;
	// multiply: acc holds upper half, quo the multiplier shifting out / lower half in
	assign sum   = {1'b0, acc_q} + (quo_q[0] ? {1'b0, dvs_q} : 33'd0);
	// divide: acc holds partial remainder
	assign trial = {acc_q, quo_q[31]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd32;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q   <= req.is_div;
			neg_q_q <= req.a[31] ^ req.b[31];
			neg_r_q <= req.a[31];
			acc_q   <= '0;
			quo_q   <= abs_a;
			dvs_q   <= abs_b;
		end else if (busy_q) begin
			if (div_q) begin
				if (!trial[32]) begin
					acc_q <= trial[31:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					acc_q <= {acc_q[30:0], quo_q[31]};
					quo_q <= {quo_q[30:0], 1'b0};
				end
			end else begin
				acc_q <= sum[32:1];
				quo_q <= {sum[0], quo_q[31:1]};
			end
		end
	end

	assign prod_abs = {acc_q, quo_q};
	assign prod     = neg_q_q ? (~prod_abs + 64'd1) : prod_abs;
	assign qf       = neg_q_q ? (~quo_q + 32'd1) : quo_q;
	assign rf       = neg_r_q ? (~acc_q + 32'd1) : acc_q;

	always_comb begin
		if (div_q) begin
			rsp.hi = rf;
			rsp.lo = qf;
		end else begin
			rsp.hi = prod[63:32];
			rsp.lo = prod[31:0];
		end
	end

endmodule

// ----- hdl/mips_exu_regfile.sv -----
// General register file, 32 x 32, one write and one registered read port.
// No dependencies; register 0 reads as zero.
module mips_exu_regfile #(
	parameter int REG_COUNT = 32
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(REG_COUNT)-1:0] waddr,
	input  logic [31:0] wdata,
	input  logic [$clog2(REG_COUNT)-1:0] raddr,
	output logic [31:0] rdata
);

	logic [31:0] mem [REG_COUNT];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= (raddr == '0) ? 32'd0 : mem[raddr];
	end

endmodule

// ----- hdl/mips_integer_execute_unit.sv -----
// Integer execute unit: single-issue MIPS32 instruction executor.
// Slave channel s_axis_* carries one instruction word per request; master channel
// m_axis_* returns one result per instruction. cfg_* writes text_limit.
// Depends on mips_exu_pkg, mips_exu_regfile, mips_exu_muldiv.
//
// After reset a clearing pass writes zero to all REG_COUNT registers, one per
// cycle with s_axis_tready low; configuration is still taken. Each instruction
// reads rs then rt (a syscall v0 then a0) through the single register file read
// port in ST_IDLE and ST_READ_A; an ALU, shift, branch or syscall result is
// registered into the output in ST_EXEC and offered in ST_DONE. MULT and DIV (DIV
// only with a nonzero divisor) run 32 steps on the shared multiply/divide unit in
// ST_ITER. A request met while halted, or with pc at or beyond text_limit, is
// answered from ST_IDLE without being executed. One instruction is in flight at a
// time: s_axis_tready is low from acceptance until its result is taken. While the
// receiver holds m_axis_tready low the result stays in the output register unchanged.
// Reset clears pc, hi, lo and halt and sets text_limit to 8192.
module mips_integer_execute_unit #(
	parameter int REG_COUNT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // instruction_word
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// next_pc[31:0], wb_valid[32], wb_index[37:33], wb_value[69:38],
	// print_valid[70], print_value[102:71], halt_flag[103], unknown_op[104]
	output logic [111:0] m_axis_tdata
);

	localparam int IW = $clog2(REG_COUNT);

	mips_exu_pkg::state_t state_q, state_d;
	logic [15:0] limit_q;
	logic [31:0] pc_q, hi_q, lo_q, ir_q, a_q, b_q, v0_q;
	logic        halted_q;
	logic [IW:0] clr_q;
	logic        clr_busy;
	logic        sys_chk_q;

	logic        rf_we;
	logic [IW-1:0] rf_waddr, rf_raddr;
	logic [31:0] rf_wdata, rf_rdata;

	mips_exu_pkg::iter_req_t ireq;
	mips_exu_pkg::iter_rsp_t irsp;
	logic [5:0] iter_cnt_q;

	logic [5:0]  op, fn;
	logic [4:0]  rs, rt, rd, sh;
	logic [31:0] imm_s, imm_z;
	logic [31:0] pc4;
	logic        wr, unk, prt, ex_halt, sys_step;
	logic [4:0]  widx;
	logic [31:0] wval, pc_nx;
	logic [32:0] diff;

	assign op = ir_q[31:26];
	assign rs = ir_q[25:21];
	assign rt = ir_q[20:16];
	assign rd = ir_q[15:11];
	assign sh = ir_q[10:6];
	assign fn = ir_q[5:0];
	assign imm_z = {16'd0, ir_q[15:0]};
	assign imm_s = {{16{ir_q[15]}}, ir_q[15:0]};
	assign pc4 = pc_q + 32'd4;

	assign clr_busy = (clr_q != REG_COUNT[IW:0]);
	assign cfg_ready = 1'b1;

	mips_exu_regfile #(.REG_COUNT(REG_COUNT)) u_rf (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.raddr(rf_raddr), .rdata(rf_rdata)
	);

	mips_exu_muldiv u_md (.clk(clk), .arst_n(arst_n), .req(ireq), .rsp(irsp));

	// Execute decode (combinational over latched operands)
	always_comb begin
		wr = 1'b0; unk = 1'b0; prt = 1'b0; ex_halt = 1'b0;
		widx = rd; wval = '0; pc_nx = pc4;
		diff = {a_q[31], a_q} - {b_q[31], b_q};
		case (op)
			mips_exu_pkg::OP_RTYPE: begin
				case (fn)
					mips_exu_pkg::FN_ADD: begin wr = 1'b1; wval = a_q + b_q; end
					mips_exu_pkg::FN_SUB: begin wr = 1'b1; wval = a_q - b_q; end
					mips_exu_pkg::FN_AND: begin wr = 1'b1; wval = a_q & b_q; end
					mips_exu_pkg::FN_OR:  begin wr = 1'b1; wval = a_q | b_q; end
					mips_exu_pkg::FN_XOR: begin wr = 1'b1; wval = a_q ^ b_q; end
					mips_exu_pkg::FN_NOR: begin wr = 1'b1; wval = ~(a_q | b_q); end
					mips_exu_pkg::FN_SLT: begin wr = 1'b1; wval = {31'd0, diff[32]}; end
					mips_exu_pkg::FN_SLL: begin wr = 1'b1; wval = b_q << sh; end
					mips_exu_pkg::FN_SRL: begin wr = 1'b1; wval = b_q >> sh; end
					mips_exu_pkg::FN_SRA: begin
						wr = 1'b1; wval = 32'($signed(b_q) >>> sh);
					end
					mips_exu_pkg::FN_MULT, mips_exu_pkg::FN_DIV: ;
					mips_exu_pkg::FN_MFHI: begin wr = 1'b1; wval = hi_q; end
					mips_exu_pkg::FN_MFLO: begin wr = 1'b1; wval = lo_q; end
					mips_exu_pkg::FN_JR: pc_nx = a_q;
					mips_exu_pkg::FN_SYS: begin
						// a_q holds a0 and v0_q holds v0 for a syscall
						if (v0_q == mips_exu_pkg::SYS_PRINT_INT) prt = 1'b1;
						else if (v0_q == mips_exu_pkg::SYS_EXIT) ex_halt = 1'b1;
					end
					default: unk = 1'b1;
				endcase
			end
			mips_exu_pkg::OP_ADDI: begin wr = 1'b1; widx = rt; wval = a_q + imm_s; end
			mips_exu_pkg::OP_SLTI: begin
				wr = 1'b1; widx = rt;
				wval = {31'd0, ($signed(a_q) < $signed(imm_s))};
			end
			mips_exu_pkg::OP_SLTIU: begin
				wr = 1'b1; widx = rt; wval = {31'd0, (a_q < imm_s)};
			end
			mips_exu_pkg::OP_ANDI: begin wr = 1'b1; widx = rt; wval = a_q & imm_z; end
			mips_exu_pkg::OP_ORI:  begin wr = 1'b1; widx = rt; wval = a_q | imm_z; end
			mips_exu_pkg::OP_XORI: begin wr = 1'b1; widx = rt; wval = a_q ^ imm_z; end
			mips_exu_pkg::OP_LUI:  begin wr = 1'b1; widx = rt; wval = {ir_q[15:0], 16'd0}; end
			mips_exu_pkg::OP_BEQ:
				if (a_q == b_q) pc_nx = pc4 + {imm_s[29:0], 2'b00};
			mips_exu_pkg::OP_BNE:
				if (a_q != b_q) pc_nx = pc4 + {imm_s[29:0], 2'b00};
			default: unk = 1'b1;
		endcase
		// no write, or a write to register zero: report index and value as zero
		if (!wr || widx == 5'd0) begin
			wr = 1'b0; widx = '0; wval = '0;
		end
	end

	assign sys_step = (op == mips_exu_pkg::OP_RTYPE) && (fn == mips_exu_pkg::FN_SYS);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mips_exu_pkg::ST_IDLE:
				if (s_axis_tvalid && !clr_busy) begin
					if (halted_q || ({16'd0, limit_q} <= pc_q))
						state_d = mips_exu_pkg::ST_DONE;
					else
						state_d = mips_exu_pkg::ST_READ_A;
				end
			mips_exu_pkg::ST_READ_A: state_d = mips_exu_pkg::ST_READ_B;
			mips_exu_pkg::ST_READ_B: state_d = mips_exu_pkg::ST_EXEC;
			mips_exu_pkg::ST_EXEC:
				if (op == mips_exu_pkg::OP_RTYPE &&
				    (fn == mips_exu_pkg::FN_MULT || (fn == mips_exu_pkg::FN_DIV && b_q != 32'd0)))
					state_d = mips_exu_pkg::ST_ITER;
				else
					state_d = mips_exu_pkg::ST_DONE;
			mips_exu_pkg::ST_ITER:
				if (iter_cnt_q == 6'd0) state_d = mips_exu_pkg::ST_DONE;
			mips_exu_pkg::ST_DONE:
				if (m_axis_tready) state_d = mips_exu_pkg::ST_IDLE;
			default: state_d = mips_exu_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		s_axis_tready = (state_q == mips_exu_pkg::ST_IDLE) && !clr_busy;
		m_axis_tvalid = (state_q == mips_exu_pkg::ST_DONE);
		rf_we = 1'b0;
		rf_waddr = '0;
		rf_wdata = '0;
		rf_raddr = IW'(rs);
		if (clr_busy) begin
			rf_we = 1'b1;
			rf_waddr = clr_q[IW-1:0];
		end else if (state_q == mips_exu_pkg::ST_EXEC && wr && !sys_chk_q) begin
			rf_we = 1'b1;
			rf_waddr = IW'(widx);
			rf_wdata = wval;
		end
		case (state_q)
			mips_exu_pkg::ST_IDLE:   rf_raddr = IW'(s_axis_tdata[25:21]);
			mips_exu_pkg::ST_READ_A:
				rf_raddr = sys_step ? IW'(mips_exu_pkg::REG_A0) : IW'(rt);
			default: rf_raddr = sys_step ? IW'(mips_exu_pkg::REG_V0) : IW'(rt);
		endcase
		if (state_q == mips_exu_pkg::ST_IDLE && s_axis_tdata[31:26] == mips_exu_pkg::OP_RTYPE
		    && s_axis_tdata[5:0] == mips_exu_pkg::FN_SYS)
			rf_raddr = IW'(mips_exu_pkg::REG_V0);
		ireq.start  = (state_q == mips_exu_pkg::ST_EXEC) && (state_d == mips_exu_pkg::ST_ITER);
		ireq.is_div = (fn == mips_exu_pkg::FN_DIV);
		ireq.a      = a_q;
		ireq.b      = b_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mips_exu_pkg::ST_IDLE;
			limit_q      <= mips_exu_pkg::TEXT_LIMIT_RST;
			pc_q         <= '0;
			hi_q         <= '0;
			lo_q         <= '0;
			halted_q     <= 1'b0;
			clr_q        <= '0;
			iter_cnt_q   <= '0;
			sys_chk_q    <= 1'b0;
			m_axis_tdata <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) limit_q <= cfg_data;
			if (clr_busy) clr_q <= clr_q + 1'b1;
			sys_chk_q <= 1'b0;
			case (state_q)
				mips_exu_pkg::ST_IDLE:
					if (state_d == mips_exu_pkg::ST_DONE) begin
						halted_q <= 1'b1;
						m_axis_tdata <= {7'd0, 1'b0, 1'b1, 71'd0, pc_q};
					end
				mips_exu_pkg::ST_EXEC: begin
					iter_cnt_q <= 6'd33;
					if (state_d == mips_exu_pkg::ST_DONE) begin
						pc_q <= pc_nx;
						if (ex_halt || ({16'd0, limit_q} <= pc_nx)) halted_q <= 1'b1;
						m_axis_tdata <= {7'd0, unk,
						                 halted_q || ex_halt || ({16'd0, limit_q} <= pc_nx),
						                 prt ? a_q : 32'd0, prt, wval, widx, wr, pc_nx};
					end
				end
				mips_exu_pkg::ST_ITER: begin
					iter_cnt_q <= iter_cnt_q - 6'd1;
					if (iter_cnt_q == 6'd0) begin
						hi_q <= irsp.hi;
						lo_q <= irsp.lo;
						pc_q <= pc4;
						if ({16'd0, limit_q} <= pc4) halted_q <= 1'b1;
						m_axis_tdata <= {7'd0, 1'b0, ({16'd0, limit_q} <= pc4), 71'd0, pc4};
					end
				end
				default: ;
			endcase
		end
	end

	// Instruction and operand registers; for a syscall a_q takes a0 and v0_q takes v0
	always_ff @(posedge clk) begin
		case (state_q)
			mips_exu_pkg::ST_IDLE:   if (s_axis_tready) ir_q <= s_axis_tdata;
			mips_exu_pkg::ST_READ_A: if (sys_step) v0_q <= rf_rdata; else a_q <= rf_rdata;
			mips_exu_pkg::ST_READ_B: if (sys_step) a_q <= rf_rdata; else b_q <= rf_rdata;
			default: ;
		endcase
	end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for mips_integer_execute_unit: instruction words are predicted
// on entry and streamed in, results are checked field by field as they come out.
// Depends on mips_exu_pkg and the execute unit RTL.
`timescale 1ns / 1ps

module testbench;

	localparam logic [5:0] OP_LW = 6'h23;
	localparam logic [5:0] FN_BAD = 6'h01;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int SETTLE = 45;

	typedef struct packed {
		logic        unknown_op;
		logic        halt_flag;
		logic [31:0] print_value;
		logic        print_valid;
		logic [31:0] wb_value;
		logic [4:0]  wb_index;
		logic        wb_valid;
		logic [31:0] next_pc;
	} exu_result_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [15:0]  cfg_data;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [31:0]  s_axis_tdata;   // instruction_word
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// next_pc, wb_valid, wb_index, wb_value, print_valid, print_value, halt_flag, unknown_op
	logic [111:0] m_axis_tdata;

	mips_integer_execute_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// architectural state of the predictor, plus a snapshot for trial execution
	logic [31:0] gpr [32];
	logic [31:0] hi_q, lo_q, pc_q;
	logic        halt_q;
	logic [15:0] limit_q;
	logic [31:0] gpr_s [32];
	logic [31:0] hi_s, lo_s, pc_s;
	logic        halt_s;

	logic [31:0] instr_fifo[$];
	exu_result_t due_results[$];
	int errors = 0;
	int results_seen = 0;
	int cycles = 0;
	bit burst = 0;

	function automatic logic [31:0] rtype(int rs, int rt, int rd, int sh, logic [5:0] fn);
		return {mips_exu_pkg::OP_RTYPE, 5'(rs), 5'(rt), 5'(rd), 5'(sh), fn};
	endfunction

	function automatic logic [31:0] itype(logic [5:0] op, int rs, int rt, int imm);
		return {op, 5'(rs), 5'(rt), 16'(imm)};
	endfunction

	function automatic exu_result_t execute_word(logic [31:0] w);
		logic [5:0]  op, fn;
		logic [4:0]  rs, rt, rd, sh, widx;
		logic [15:0] imm;
		logic [31:0] a, b, sx, npc, wv;
		logic [63:0] prod;
		logic        wr, unk;
		exu_result_t r;
		r = '0;
		if (halt_q || pc_q >= {16'b0, limit_q}) begin
			halt_q = 1'b1;
			r.next_pc = pc_q;
			r.halt_flag = 1'b1;
			return r;
		end
		{op, rs, rt, rd, sh, fn} = w;
		imm = w[15:0];
		sx = {{16{imm[15]}}, imm};
		a = gpr[rs];
		b = gpr[rt];
		npc = pc_q + 32'd4;
		wr = 1'b0; unk = 1'b0; widx = rd; wv = '0;
		case (op)
			mips_exu_pkg::OP_RTYPE: begin
				wr = 1'b1;
				case (fn)
					mips_exu_pkg::FN_ADD: wv = a + b;
					mips_exu_pkg::FN_SUB: wv = a - b;
					mips_exu_pkg::FN_AND: wv = a & b;
					mips_exu_pkg::FN_OR:  wv = a | b;
					mips_exu_pkg::FN_XOR: wv = a ^ b;
					mips_exu_pkg::FN_NOR: wv = ~(a | b);
					mips_exu_pkg::FN_SLT: wv = {31'b0, $signed(a) < $signed(b)};
					mips_exu_pkg::FN_SLL: wv = b << sh;
					mips_exu_pkg::FN_SRL: wv = b >> sh;
					mips_exu_pkg::FN_SRA: wv = $signed(b) >>> sh;
					mips_exu_pkg::FN_MFHI: wv = hi_q;
					mips_exu_pkg::FN_MFLO: wv = lo_q;
					mips_exu_pkg::FN_MULT: begin
						wr = 1'b0;
						prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
						{hi_q, lo_q} = prod;
					end
					mips_exu_pkg::FN_DIV: begin
						wr = 1'b0;
						if (b != 0) begin
							if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
								lo_q = 32'h8000_0000;
								hi_q = '0;
							end else begin
								lo_q = $signed(a) / $signed(b);
								hi_q = $signed(a) % $signed(b);
							end
						end
					end
					mips_exu_pkg::FN_JR: begin
						wr = 1'b0;
						npc = a;
					end
					mips_exu_pkg::FN_SYS: begin
						wr = 1'b0;
						if (gpr[mips_exu_pkg::REG_V0] == mips_exu_pkg::SYS_PRINT_INT) begin
							r.print_valid = 1'b1;
							r.print_value = gpr[mips_exu_pkg::REG_A0];
						end else if (gpr[mips_exu_pkg::REG_V0] == mips_exu_pkg::SYS_EXIT) begin
							halt_q = 1'b1;
						end
					end
					default: begin
						wr = 1'b0;
						unk = 1'b1;
					end
				endcase
			end
			mips_exu_pkg::OP_ADDI: begin wr = 1'b1; widx = rt; wv = a + sx; end
			mips_exu_pkg::OP_SLTI: begin
				wr = 1'b1; widx = rt; wv = {31'b0, $signed(a) < $signed(sx)};
			end
			mips_exu_pkg::OP_SLTIU: begin wr = 1'b1; widx = rt; wv = {31'b0, a < sx}; end
			mips_exu_pkg::OP_ANDI:  begin wr = 1'b1; widx = rt; wv = a & {16'b0, imm}; end
			mips_exu_pkg::OP_ORI:   begin wr = 1'b1; widx = rt; wv = a | {16'b0, imm}; end
			mips_exu_pkg::OP_XORI:  begin wr = 1'b1; widx = rt; wv = a ^ {16'b0, imm}; end
			mips_exu_pkg::OP_LUI:   begin wr = 1'b1; widx = rt; wv = {imm, 16'b0}; end
			mips_exu_pkg::OP_BEQ: if (a == b) npc = pc_q + 32'd4 + (sx << 2);
			mips_exu_pkg::OP_BNE: if (a != b) npc = pc_q + 32'd4 + (sx << 2);
			default: unk = 1'b1;
		endcase
		if (wr && widx != 0) begin
			gpr[widx] = wv;
			r.wb_valid = 1'b1;
			r.wb_index = widx;
			r.wb_value = wv;
		end
		pc_q = npc;
		if (pc_q >= {16'b0, limit_q})
			halt_q = 1'b1;
		r.next_pc = pc_q;
		r.halt_flag = halt_q;
		r.unknown_op = unk;
		return r;
	endfunction

	task automatic issue(logic [31:0] w);
		due_results.push_back(execute_word(w));
		instr_fifo.push_back(w);
	endtask

	// random instructions must not halt the unit before the final phase
	task automatic try_issue(logic [31:0] w, output bit ok);
		exu_result_t r;
		gpr_s = gpr; hi_s = hi_q; lo_s = lo_q; pc_s = pc_q; halt_s = halt_q;
		r = execute_word(w);
		ok = !halt_q;
		if (ok) begin
			due_results.push_back(r);
			instr_fifo.push_back(w);
		end else begin
			gpr = gpr_s; hi_q = hi_s; lo_q = lo_s; pc_q = pc_s; halt_q = halt_s;
		end
	endtask

	task automatic random_items(int n);
		int count, kind, reg_x, span;
		logic [5:0] fn;
		bit ok;
		logic [5:0] alu_fns [12] = '{mips_exu_pkg::FN_ADD, mips_exu_pkg::FN_SUB,
			mips_exu_pkg::FN_AND, mips_exu_pkg::FN_OR, mips_exu_pkg::FN_XOR,
			mips_exu_pkg::FN_NOR, mips_exu_pkg::FN_SLT, mips_exu_pkg::FN_SLL,
			mips_exu_pkg::FN_SRL, mips_exu_pkg::FN_SRA, mips_exu_pkg::FN_MFHI,
			mips_exu_pkg::FN_MFLO};
		logic [5:0] imm_ops [7] = '{mips_exu_pkg::OP_ADDI, mips_exu_pkg::OP_SLTI,
			mips_exu_pkg::OP_SLTIU, mips_exu_pkg::OP_ANDI, mips_exu_pkg::OP_ORI,
			mips_exu_pkg::OP_XORI, mips_exu_pkg::OP_LUI};
		count = 0;
		while (count < n) begin
			@(negedge clk);
			while (instr_fifo.size() > 8)
				@(negedge clk);
			if (pc_q + 32'd256 >= {16'b0, limit_q}) begin
				issue(rtype(0, 0, 0, 0, mips_exu_pkg::FN_JR));
				count++;
				continue;
			end
			kind = $urandom_range(0, 99);
			ok = 1'b0;
			if (kind < 30) begin
				fn = alu_fns[$urandom_range(0, 11)];
				try_issue(rtype($urandom_range(0, 31), $urandom_range(0, 31),
					$urandom_range(0, 31), $urandom_range(0, 31), fn), ok);
			end else if (kind < 60) begin
				try_issue(itype(imm_ops[$urandom_range(0, 6)], $urandom_range(0, 31),
					$urandom_range(0, 31), $urandom), ok);
			end else if (kind < 70) begin
				fn = $urandom_range(0, 1) ? mips_exu_pkg::FN_MULT : mips_exu_pkg::FN_DIV;
				try_issue(rtype($urandom_range(0, 31), $urandom_range(0, 31),
					$urandom_range(0, 31), $urandom_range(0, 31), fn), ok);
			end else if (kind < 78) begin
				span = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 128) - 64;
				try_issue(itype($urandom_range(0, 1) ? mips_exu_pkg::OP_BEQ : mips_exu_pkg::OP_BNE,
					$urandom_range(0, 31), $urandom_range(0, 31), span), ok);
			end else if (kind < 84) begin
				// load a target address, then jump through it
				reg_x = $urandom_range(5, 31);
				span = limit_q < 16'd32767 ? limit_q : 32767;
				issue(itype(mips_exu_pkg::OP_ADDI, 0, reg_x, $urandom_range(0, span - 4)));
				try_issue(rtype(reg_x, 0, 0, 0, mips_exu_pkg::FN_JR), ok);
				count++;
			end else if (kind < 92) begin
				// print sequence, or a syscall with whatever code v0 holds
				if ($urandom_range(0, 2) != 0) begin
					issue(itype(mips_exu_pkg::OP_ADDI, 0, mips_exu_pkg::REG_V0,
						mips_exu_pkg::SYS_PRINT_INT));
					count++;
				end
				try_issue(rtype(0, 0, 0, 0, mips_exu_pkg::FN_SYS), ok);
			end else begin
				try_issue($urandom, ok);
			end
			if (ok)
				count++;
		end
	endtask

	task automatic settle();
		while (instr_fifo.size() != 0 || due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_limit(logic [15:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_q = v;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		for (int i = 0; i < 32; i++)
			gpr[i] = '0;
		hi_q = '0; lo_q = '0; pc_q = '0; halt_q = 1'b0;
		limit_q = mips_exu_pkg::TEXT_LIMIT_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		issue(itype(mips_exu_pkg::OP_LUI, 0, 8, 16'h8000));
		issue(itype(mips_exu_pkg::OP_ADDI, 0, 9, 16'hFFFF));
		issue(rtype(8, 9, 10, 0, mips_exu_pkg::FN_ADD));
		issue(rtype(0, 8, 11, 0, mips_exu_pkg::FN_SUB));
		issue(rtype(8, 9, 12, 0, mips_exu_pkg::FN_SLT));
		issue(itype(mips_exu_pkg::OP_SLTIU, 0, 13, 16'hFFFF));
		issue(itype(mips_exu_pkg::OP_SLTI, 9, 14, 16'h8000));
		issue(rtype(0, 8, 15, 31, mips_exu_pkg::FN_SRA));
		issue(rtype(0, 9, 16, 31, mips_exu_pkg::FN_SRL));
		issue(rtype(0, 9, 17, 31, mips_exu_pkg::FN_SLL));
		issue(rtype(8, 0, 18, 0, mips_exu_pkg::FN_NOR));
		issue(itype(mips_exu_pkg::OP_XORI, 9, 19, 16'hFFFF));
		issue(rtype(9, 9, 0, 0, mips_exu_pkg::FN_ADD));
		issue(rtype(8, 8, 0, 0, mips_exu_pkg::FN_MULT));
		issue(rtype(0, 0, 20, 0, mips_exu_pkg::FN_MFHI));
		issue(rtype(8, 9, 0, 0, mips_exu_pkg::FN_DIV));
		issue(rtype(0, 0, 21, 0, mips_exu_pkg::FN_MFLO));
		issue(rtype(9, 0, 0, 0, mips_exu_pkg::FN_DIV));
		issue(rtype(0, 0, 22, 0, mips_exu_pkg::FN_MFHI));
		issue(itype(mips_exu_pkg::OP_ADDI, 0, mips_exu_pkg::REG_V0,
			mips_exu_pkg::SYS_PRINT_INT));
		issue(rtype(0, 0, 0, 0, mips_exu_pkg::FN_SYS));
		issue(itype(mips_exu_pkg::OP_BNE, 8, 0, 1));
		issue(itype(mips_exu_pkg::OP_BEQ, 8, 0, 16'hFFF0));
		issue({OP_LW, 26'h0});
		issue(rtype(0, 0, 0, 0, FN_BAD));
		issue(rtype(0, 0, 0, 0, mips_exu_pkg::FN_JR));

		settle();
		write_limit(16'hFFFC);
		random_items(700);
		issue(rtype(0, 0, 0, 0, mips_exu_pkg::FN_JR));
		settle();
		write_limit(16'd1000);
		random_items(500);
		issue(rtype(0, 0, 0, 0, mips_exu_pkg::FN_JR));
		settle();
		write_limit(mips_exu_pkg::TEXT_LIMIT_RST);
		random_items(550);
		issue(rtype(0, 0, 0, 0, mips_exu_pkg::FN_JR));
		settle();
		// halt either by the exit syscall or by running into the limit
		if ($urandom_range(0, 1)) begin
			write_limit(16'd12);
			issue(itype(mips_exu_pkg::OP_ADDI, 0, mips_exu_pkg::REG_V0,
				mips_exu_pkg::SYS_EXIT));
			issue(rtype(0, 0, 0, 0, mips_exu_pkg::FN_SYS));
		end else begin
			write_limit(16'd4);
			issue(itype(mips_exu_pkg::OP_ADDI, 0, 5, 7));
		end
		issue($urandom);
		issue($urandom);
		settle();
		write_limit(16'd4);
		issue($urandom);
		issue($urandom);
		settle();
		if (errors == 0)
			$display("mips_integer_execute_unit regression: pass");
		else
			$display("mips_integer_execute_unit regression: fail");
		$finish;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("mips_integer_execute_unit regression: fail");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			send_gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				void'(instr_fifo.pop_front());
			if (s_axis_tvalid && !s_axis_tready) begin
				// request still waiting: hold it
			end else if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (instr_fifo.size() > 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= instr_fifo[0];
				send_gap = pick_gap();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// one long hold-off on the result side while requests keep coming
	int hold_left = 0;
	bit hold_done = 0;
	always @(posedge clk) begin
		if (results_seen == 300 && !hold_done) begin
			hold_left <= 700;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	int take_stall = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			take_stall = 0;
		end else if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
		end else if (take_stall > 0) begin
			take_stall--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				take_stall = pick_gap();
		end
	end

	always @(posedge clk)
		if (cycles % 400 == 0)
			burst <= $urandom_range(0, 3) == 0;

	task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			$display("%0t: %s expected %h got %h", $time, name, e, a);
			errors++;
		end
	endtask

	always @(posedge clk) begin : result_check
		exu_result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[104:0];
			results_seen++;
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result expected none got %h", $time, got);
				errors++;
			end else begin
				want = due_results.pop_front();
				check_field("next_pc", want.next_pc, got.next_pc);
				check_field("wb_valid", want.wb_valid, got.wb_valid);
				check_field("wb_index", want.wb_index, got.wb_index);
				check_field("wb_value", want.wb_value, got.wb_value);
				check_field("print_valid", want.print_valid, got.print_valid);
				check_field("print_value", want.print_value, got.print_value);
				check_field("halt_flag", want.halt_flag, got.halt_flag);
				check_field("unknown_op", want.unknown_op, got.unknown_op);
			end
		end
	end

endmodule
